// ----- rtl/positional_list_insert_delete_search_top_assert.svh -----
// Assertion macros for the positional list block, clocked on clock, disabled in reset.
`ifndef POSITIONAL_LIST_INSERT_DELETE_SEARCH_TOP_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_SEARCH_TOP_ASSERT_SVH

// condition must hold on every edge
`define PLIST_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("positional list: invariant violated");

// same-cycle implication
`define PLIST_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("positional list: implication violated");

// next-cycle implication
`define PLIST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("positional list: next-cycle implication violated");

`endif

// ----- rtl/pos_list_pkg.sv -----
// Shared types and constants for the positional list block.
`timescale 1ns / 1ps
package pos_list_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int ELEM_BITS_DEF = 32;

   localparam int CMD_W = 2;
   localparam int POS_W = 5;
   localparam int VAL_W = 32;
   localparam int LVL_W = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the incoming request
      logic execute;   // apply insert/delete, build locate match vector
      logic scan;      // encode first match of a locate
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_locate;
   } ctl_sts_type;

endpackage

// ----- rtl/pos_list_req_if.sv -----
// Request channel interface of the positional list block.
`timescale 1ns / 1ps
interface pos_list_req_if;
   logic                             valid;
   logic                             ready;
   logic [pos_list_pkg::CMD_W-1:0]   command;
   logic [pos_list_pkg::POS_W-1:0]   position;
   logic signed [pos_list_pkg::VAL_W-1:0] value;

   modport source (output valid, output command, output position, output value,
                   input ready);
   modport sink   (input valid, input command, input position, input value,
                   output ready);
endinterface

// ----- rtl/pos_list_rsp_if.sv -----
// Response channel interface of the positional list block.
`timescale 1ns / 1ps
interface pos_list_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  ok;
   logic signed [pos_list_pkg::VAL_W-1:0] removed_value;
   logic [pos_list_pkg::POS_W-1:0]        found_position;
   logic [pos_list_pkg::LVL_W-1:0]        fill_level;

   modport source (output valid, output ok, output removed_value,
                   output found_position, output fill_level, input ready);
   modport sink   (input valid, input ok, input removed_value,
                   input found_position, input fill_level, output ready);
endinterface

// ----- rtl/pos_list_ctrl.sv -----
// Sequencing state machine of the positional list block.
`timescale 1ns / 1ps
module pos_list_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  pos_list_pkg::ctl_sts_type  sts,
   output pos_list_pkg::ctl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   // a new request may enter in the cycle the previous response leaves
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_RESP) && rsp_ready);
   assign rsp_valid = (state_ff == ST_RESP);
   assign accept    = req_valid && req_ready;

   assign cmd.capture = accept;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign cmd.scan    = (state_ff == ST_SCAN);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = sts.is_locate ? ST_SCAN : ST_RESP;
         end
         ST_SCAN: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (accept)         state_in = ST_EXEC;
            else if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- rtl/pos_list_dpath.sv -----
// Element store, fill count and result registers of the positional list block.
`timescale 1ns / 1ps
module pos_list_dpath #(
   parameter int DEPTH     = pos_list_pkg::DEPTH_DEF,
   parameter int ELEM_BITS = pos_list_pkg::ELEM_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pos_list_pkg::ctl_cmd_type              cmd,
   output pos_list_pkg::ctl_sts_type              sts,
   input  logic [pos_list_pkg::CMD_W-1:0]         req_command,
   input  logic [pos_list_pkg::POS_W-1:0]         req_position,
   input  logic signed [pos_list_pkg::VAL_W-1:0]  req_value,
   output logic                                   rsp_ok,
   output logic signed [pos_list_pkg::VAL_W-1:0]  rsp_removed_value,
   output logic [pos_list_pkg::POS_W-1:0]         rsp_found_position,
   output logic [pos_list_pkg::LVL_W-1:0]         rsp_fill_level
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = ((CNT_W > pos_list_pkg::POS_W) ? CNT_W : pos_list_pkg::POS_W) + 1;

   logic [pos_list_pkg::CMD_W-1:0] cmd_ff;
   logic [pos_list_pkg::POS_W-1:0] pos_ff;
   logic [ELEM_BITS-1:0]           key_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [CNT_W-1:0]               count_in;
   logic [ELEM_BITS-1:0]           store_ff [DEPTH];
   logic [ELEM_BITS-1:0]           store_in [DEPTH];
   logic [DEPTH-1:0]               match_ff;
   logic [DEPTH-1:0]               match_in;
   logic                           ok_ff;
   logic [ELEM_BITS-1:0]           removed_ff;
   logic [pos_list_pkg::POS_W-1:0] found_ff;
   logic [pos_list_pkg::POS_W-1:0] found_enc;

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] slot_ext;
   logic [IDX_W-1:0] slot_idx;
   logic             list_full;
   logic             ins_ok;
   logic             del_ok;
   logic             do_ins;
   logic             do_del;

   assign sts.is_locate = (cmd_ff == pos_list_pkg::CMD_LOCATE);

   assign pos_ext   = CMP_W'(pos_ff);
   assign cnt_ext   = CMP_W'(count_ff);
   assign slot_ext  = pos_ext - CMP_W'(1);
   assign slot_idx  = slot_ext[IDX_W-1:0];
   assign list_full = (count_ff == CNT_W'(DEPTH));
   assign ins_ok    = !list_full && (pos_ff != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
   assign del_ok    = (pos_ff != '0) && (pos_ext <= cnt_ext);
   assign do_ins    = cmd.execute && (cmd_ff == pos_list_pkg::CMD_INSERT) && ins_ok;
   assign do_del    = cmd.execute && (cmd_ff == pos_list_pkg::CMD_DELETE) && del_ok;

   // each entry looks only at itself, its two neighbours and the captured key
   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      logic [ELEM_BITS-1:0] below;
      logic [ELEM_BITS-1:0] above;
      logic [CMP_W-1:0]     here;

      assign here  = CMP_W'(i);
      assign below = (i == 0) ? key_ff : store_ff[(i == 0) ? 0 : i - 1];
      assign above = (i == DEPTH - 1) ? store_ff[i] : store_ff[(i == DEPTH - 1) ? i : i + 1];

      always_comb begin
         store_in[i] = store_ff[i];
         if (do_ins) begin
            if (here == slot_ext)
               store_in[i] = key_ff;
            else if ((here > slot_ext) && (here <= cnt_ext))
               store_in[i] = below;
         end else if (do_del) begin
            if ((here >= slot_ext) && (here + CMP_W'(1) < cnt_ext))
               store_in[i] = above;
         end
      end

      assign match_in[i] = (store_ff[i] == key_ff) && (here < cnt_ext);

      always_ff @(posedge clock) begin
         store_ff[i] <= store_in[i];
      end
   end

   // first match wins: walk down so the lowest index is written last
   always_comb begin
      found_enc = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) found_enc = pos_list_pkg::POS_W'(i + 1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins)      count_in = count_ff + CNT_W'(1);
      else if (do_del) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_command;
         pos_ff <= req_position;
         key_ff <= ELEM_BITS'($unsigned(req_value));
      end
      if (cmd.execute) begin
         match_ff   <= match_in;
         ok_ff      <= do_ins || do_del;
         removed_ff <= do_del ? store_ff[slot_idx] : '0;
         found_ff   <= '0;
      end
      if (cmd.scan) begin
         ok_ff    <= |match_ff;
         found_ff <= found_enc;
      end
   end

   assign rsp_ok             = ok_ff;
   assign rsp_removed_value  = $signed(pos_list_pkg::VAL_W'(removed_ff));
   assign rsp_found_position = found_ff;
   assign rsp_fill_level     = pos_list_pkg::LVL_W'(count_ff);

endmodule

// ----- rtl/positional_list_insert_delete_search_top.sv -----
// Top level of the positional list block: controller, datapath and checks.
`timescale 1ns / 1ps
// Ordered list of up to DEPTH elements with insert at a 1-based position,
// delete at a 1-based position and locate-by-value; every request yields one
// response carrying success, the removed element, the first match position and
// the fill level after the request. A request passes through the execute
// step (shift of the register store and parallel compare) and, for locate,
// through the match encoder step as well before its response goes valid. The
// next request is taken in the cycle its predecessor's response is taken, so a
// new request is never accepted while an earlier one is still in flight.
// The store needs no clearing after reset; only entries below the fill level are read.
module positional_list_insert_delete_search_top #(
   parameter int DEPTH     = pos_list_pkg::DEPTH_DEF,
   parameter int ELEM_BITS = pos_list_pkg::ELEM_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   pos_list_req_if.sink   req_ch,
   pos_list_rsp_if.source rsp_ch
);

   pos_list_pkg::ctl_cmd_type ctl_cmd;
   pos_list_pkg::ctl_sts_type ctl_sts;
   logic                      rsp_fields_clear;

   pos_list_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (ctl_sts),
      .cmd       (ctl_cmd)
   );

   pos_list_dpath #(
      .DEPTH     (DEPTH),
      .ELEM_BITS (ELEM_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctl_cmd),
      .sts                (ctl_sts),
      .req_command        (req_ch.command),
      .req_position       (req_ch.position),
      .req_value          (req_ch.value),
      .rsp_ok             (rsp_ch.ok),
      .rsp_removed_value  (rsp_ch.removed_value),
      .rsp_found_position (rsp_ch.found_position),
      .rsp_fill_level     (rsp_ch.fill_level)
   );

   assign rsp_fields_clear = (rsp_ch.removed_value == '0) && (rsp_ch.found_position == '0);

`include "positional_list_insert_delete_search_top_assert.svh"

   // only one request in flight
   `PLIST_ASSERT_NEXT(a_one_in_flight, req_ch.valid && req_ch.ready, !req_ch.ready)
   // a pending response blocks new requests
   `PLIST_ASSERT_IMPL(a_resp_blocks, rsp_ch.valid && !rsp_ch.ready, !req_ch.ready)
   `PLIST_ASSERT_IMPL(a_found_means_ok, rsp_ch.valid && rsp_ch.found_position != '0, rsp_ch.ok)
   `PLIST_ASSERT_IMPL(a_fail_is_clean, rsp_ch.valid && !rsp_ch.ok, rsp_fields_clear)

endmodule
